// File: sv/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants, register indexes and helpers for the glob matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned WORD_BYTES = 8;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: sv/gwm_closure.sv
// ----------------------------------------------------------------------------
// gwm_closure
// Star closure of a position set as a parallel prefix OR.
// ----------------------------------------------------------------------------
module gwm_closure #(
  parameter int unsigned PATTERN_CHARS = 32
) (
  input  logic [PATTERN_CHARS:0]   set_i,
  input  logic [PATTERN_CHARS-1:0] star_i,
  output logic [PATTERN_CHARS:0]   set_o
);

  localparam int unsigned W      = PATTERN_CHARS + 1;
  localparam int unsigned LEVELS = $clog2(W);

  // p[l][j]: every link from the span start into j is a star
  logic [W-1:0] g [LEVELS+1];
  logic [W-1:0] p [LEVELS+1];

  assign g[0] = set_i;
  assign p[0] = {star_i, 1'b0};

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < W; j++) begin : g_bit
      if (j >= (1 << l)) begin : g_comb
        assign g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-(1<<l)]);
        assign p[l+1][j] = p[l][j] & p[l][j-(1<<l)];
      end else begin : g_pass
        assign g[l+1][j] = g[l][j];
        assign p[l+1][j] = p[l][j];
      end
    end
  end

  assign set_o = g[LEVELS];

endmodule

// File: sv/gwm_step.sv
// ----------------------------------------------------------------------------
// gwm_step
// One character of the position set update, star closure and match select.
// ----------------------------------------------------------------------------
module gwm_step #(
  parameter int unsigned PATTERN_CHARS = 32
) (
  input  logic [PATTERN_CHARS:0]         cur_i,
  input  logic [gwm_pkg::CHAR_W-1:0]     char_i,
  input  logic [gwm_pkg::CHAR_W-1:0]     pat_i [PATTERN_CHARS],
  input  logic [PATTERN_CHARS-1:0]       use_i,
  input  logic [PATTERN_CHARS-1:0]       star_i,
  input  logic [gwm_pkg::LEN_W-1:0]      len_i,
  output logic [PATTERN_CHARS:0]         next_o,
  output logic                           matched_o
);

  import gwm_pkg::*;

  logic [PATTERN_CHARS-1:0] hit;
  logic [PATTERN_CHARS-1:0] keep;
  logic [PATTERN_CHARS:0]   raw;

  always_comb begin
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      keep[i] = cur_i[i] & star_i[i];
      hit[i]  = cur_i[i] & use_i[i] & ~star_i[i] &
                ((pat_i[i] == ANY_CHAR) | (pat_i[i] == char_i));
    end
  end

  assign raw = {hit, 1'b0} | {1'b0, keep};

  gwm_closure #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_closure (
    .set_i  (raw),
    .star_i (star_i),
    .set_o  (next_o)
  );

  always_comb begin
    matched_o = 1'b0;
    for (int i = 0; i <= PATTERN_CHARS; i++) begin
      if (len_i == LEN_W'(i)) begin
        matched_o = next_o[i];
      end
    end
  end

endmodule

// File: sv/glob_wildcard_matcher_top.sv
// Bytes register in s1; only a tlast byte, on advancing, loads the result register.
// Throughput: one byte per cycle unless a last byte waits on a stalled result.
// The position set updates through a combinational prefix-OR star closure.
// Reset: pattern and length clear to zero, position set is the start closure.
// A pattern register write restarts the name in progress.
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_top
// Case-insensitive glob match of a streamed name against a register pattern.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_top #(
  parameter int unsigned PATTERN_CHARS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] text_char
  input  logic                              s_axis_tlast,  // last_char
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata   // [0] matched, [7:1] zero
);

  import gwm_pkg::*;

  localparam int unsigned W = PATTERN_CHARS + 1;

  logic [CHAR_W-1:0]        pat_q [PATTERN_CHARS];
  logic [LEN_W-1:0]         len_q;
  logic                     fresh_q;
  logic [W-1:0]             act_q;
  logic                     s1_valid_q;
  logic                     s1_last_q;
  logic [CHAR_W-1:0]        s1_char_q;
  logic                     out_valid_q;
  logic                     matched_q;

  logic                     cfg_hit;
  logic [LEN_W-1:0]         len_used;
  logic [PATTERN_CHARS-1:0] use_vec;
  logic [PATTERN_CHARS-1:0] star_vec;
  logic [W-1:0]             start_set;
  logic [W-1:0]             cur_set;
  logic [W-1:0]             next_set;
  logic                     step_match;
  logic                     adv;

  always_comb begin
    unique case (cfg_idx_i) inside
      REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3, REG_LEN: cfg_hit = cfg_we_i;
      default:                                         cfg_hit = 1'b0;
    endcase
  end

  for (genvar b = 0; b < PATTERN_CHARS; b++) begin : g_pat
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pat_q[b] <= '0;
      end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(b / WORD_BYTES)) begin
        pat_q[b] <= fold_case(cfg_data_i[(b % WORD_BYTES)*CHAR_W +: CHAR_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == REG_LEN) begin
      len_q <= cfg_data_i[LEN_W-1:0];
    end
  end

  assign len_used = (len_q > LEN_W'(PATTERN_CHARS)) ? LEN_W'(PATTERN_CHARS) : len_q;

  always_comb begin
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      use_vec[i]  = LEN_W'(i) < len_used;
      star_vec[i] = use_vec[i] & (pat_q[i] == STAR_CHAR);
    end
  end

  gwm_closure #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_start (
    .set_i  (W'(1)),
    .star_i (star_vec),
    .set_o  (start_set)
  );

  assign cur_set = fresh_q ? start_set : act_q;

  gwm_step #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_step (
    .cur_i     (cur_set),
    .char_i    (s1_char_q),
    .pat_i     (pat_q),
    .use_i     (use_vec),
    .star_i    (star_vec),
    .len_i     (len_used),
    .next_o    (next_set),
    .matched_o (step_match)
  );

  assign adv           = s1_valid_q & (~s1_last_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_char_q <= fold_case(s_axis_tdata);
      s1_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      act_q   <= '0;
    end else if (cfg_hit) begin
      fresh_q <= 1'b1;
    end else if (adv) begin
      fresh_q <= s1_last_q;
      act_q   <= next_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      matched_q   <= 1'b0;
    end else if (adv && s1_last_q) begin
      out_valid_q <= 1'b1;
      matched_q   <= step_match;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, matched_q};

  a_rise_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result raised without a last byte");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && s1_valid_q && s1_last_q && !cfg_hit)
      |=> (s1_valid_q && s1_last_q && out_valid_q))
    else $error("last byte dropped while result stalled");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_last_q) |=> fresh_q)
    else $error("position set not restarted after end of name");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the case-insensitive glob matcher.
// Names are streamed byte by byte against a series of register patterns.
// An in-bench position-set predictor computes each name's match flag, and
// the monitor compares every result transfer against it, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gwm_pkg::*;

  localparam int unsigned N_CHARS = 32;
  localparam int unsigned N_PHASES = 24;
  localparam int unsigned PHASE_BYTES = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } name_byte_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;

  // predictor state
  logic [63:0] pat_words[4];
  logic [5:0]  pat_len;
  logic [32:0] reach;

  name_byte_t  pending[$];
  logic        match_q[$];
  logic [7:0]  new_pat[N_CHARS];
  logic [7:0]  name_buf[$];

  int unsigned errors = 0;
  int unsigned names_done = 0;
  int unsigned names_hit = 0;
  int unsigned settings = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          burst_in = 1'b0;
  bit          burst_out = 1'b0;
  logic        drv_valid;
  name_byte_t  cur;

  glob_wildcard_matcher_top #(
    .PATTERN_CHARS(N_CHARS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] text_char
    .s_axis_tlast  (s_axis_tlast),   // last_char
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [0] matched, [7:1] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic int unsigned span();
    return (pat_len > N_CHARS) ? N_CHARS : int'(pat_len);
  endfunction

  function automatic logic [7:0] pat_char(input int unsigned i);
    return pat_words[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [32:0] close_stars(input logic [32:0] s);
    logic [32:0] r;
    r = s;
    for (int unsigned i = 0; i < span(); i++) begin
      if (r[i] && pat_char(i) == STAR_CHAR) begin
        r[i + 1] = 1'b1;
      end
    end
    return r;
  endfunction

  // advance the reachable position set by one name byte
  function automatic void advance(input logic [7:0] ch, input logic lst);
    logic [32:0]  nxt;
    logic [7:0]   c;
    logic [7:0]   p;
    int unsigned  n;
    c = lower_ascii(ch);
    n = span();
    nxt = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (reach[i]) begin
        p = pat_char(i);
        if (p == STAR_CHAR) begin
          nxt[i] = 1'b1;
        end else if (p == ANY_CHAR || lower_ascii(p) == c) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    reach = close_stars(nxt);
    if (lst) begin
      match_q.push_back(reach[n]);
      names_done++;
      if (reach[n]) begin
        names_hit++;
      end
      reach = close_stars(33'd1);
    end
  endfunction

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    if (errors < 20) begin
      $display("ERROR @%0t: %s, expected %h got %h", $time, what, want, got);
    end
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      drv_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        advance(s_axis_tdata, s_axis_tlast);
        drv_valid = 1'b0;
        send_gap = burst_in ? 0 : $urandom_range(0, 3);
      end
      if (!drv_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          s_axis_tdata <= cur.ch;
          s_axis_tlast <= cur.lst;
          drv_valid = 1'b1;
        end
      end
      s_axis_tvalid <= drv_valid;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (match_q.size() == 0) begin
          report("result transfer with none expected", 8'h00, m_axis_tdata);
        end else if (m_axis_tdata !== {7'b0, match_q[0]}) begin
          report("matched flag", {7'b0, match_q.pop_front()}, m_axis_tdata);
        end else begin
          void'(match_q.pop_front());
        end
        recv_stall = burst_out ? 0 : $urandom_range(0, 3);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // sampled mid-cycle so the driver and monitor updates of this edge are settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending.size() > 0 || s_axis_tvalid || match_q.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_PAT0: pat_words[0] = data;
      REG_PAT1: pat_words[1] = data;
      REG_PAT2: pat_words[2] = data;
      REG_PAT3: pat_words[3] = data;
      REG_LEN:  pat_len = data[LEN_W-1:0];
      default: ;
    endcase
    reach = close_stars(33'd1);
  endtask

  task automatic set_pattern(input logic [5:0] len, input logic [57:0] upper);
    logic [63:0] w[4];
    for (int unsigned k = 0; k < N_CHARS; k++) begin
      w[k / 8][(k % 8) * 8 +: 8] = new_pat[k];
    end
    cfg_write(REG_PAT0, w[0]);
    cfg_write(REG_PAT1, w[1]);
    cfg_write(REG_PAT2, w[2]);
    cfg_write(REG_PAT3, w[3]);
    cfg_write(REG_LEN, {upper, len});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic push_byte(input logic [7:0] ch, input logic lst);
    pending.push_back('{ch: ch, lst: lst});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], i == s.len() - 1);
    end
  endtask

  // build a name that mostly follows the pattern, sometimes damaged or random
  task automatic push_name();
    logic [7:0]  p;
    logic [7:0]  b;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    name_buf.delete();
    if (kind < 2) begin
      repeat ($urandom_range(1, 10)) name_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      for (int unsigned i = 0; i < span(); i++) begin
        p = pat_char(i);
        if (p == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) name_buf.push_back(8'($urandom_range(1, 255)));
        end else if (p == ANY_CHAR) begin
          name_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
          b = p;
          if ((lower_ascii(p) >= 8'h61 && lower_ascii(p) <= 8'h7A) && $urandom_range(0, 1)) begin
            b = p ^ 8'h20;
          end
          name_buf.push_back(b);
        end
      end
      if (kind < 5 && name_buf.size() > 0) begin
        case ($urandom_range(0, 2))
          0: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(1, 255));
          1: name_buf.delete($urandom_range(0, name_buf.size() - 1));
          default: name_buf.insert($urandom_range(0, name_buf.size()),
                                   8'($urandom_range(1, 255)));
        endcase
      end
    end
    if (name_buf.size() == 0) begin
      name_buf.push_back(8'($urandom_range(1, 255)));
    end
    foreach (name_buf[j]) begin
      push_byte(name_buf[j], j == name_buf.size() - 1);
    end
  endtask

  task automatic random_pattern(output logic [5:0] len);
    int unsigned r;
    foreach (new_pat[k]) begin
      r = $urandom_range(0, 19);
      if (r < 6) begin
        new_pat[k] = STAR_CHAR;
      end else if (r < 9) begin
        new_pat[k] = ANY_CHAR;
      end else if (r < 17) begin
        new_pat[k] = 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      end else begin
        new_pat[k] = 8'($urandom_range(1, 255));
      end
    end
    case ($urandom_range(0, 9))
      0: len = 6'd0;
      1: len = 6'd32;
      2: len = 6'($urandom_range(33, 63));
      default: len = 6'($urandom_range(1, 12));
    endcase
  endtask

  initial begin
    int unsigned start_sz;
    int unsigned added;
    logic [5:0]  len;
    pat_words = '{default: '0};
    pat_len = '0;
    reach = 33'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pattern after reset: nothing but the empty name matches
    push_str("a");
    wait_idle();

    // lone star, high text byte
    new_pat = '{default: 8'h00};
    new_pat[0] = STAR_CHAR;
    set_pattern(6'd1, '0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // literal, any, collapsed stars, case folding, bytes past length ignored
    new_pat = '{default: 8'h78};
    new_pat[0] = "a";
    new_pat[1] = ANY_CHAR;
    new_pat[2] = STAR_CHAR;
    new_pat[3] = STAR_CHAR;
    new_pat[4] = "C";
    set_pattern(6'd5, '1);
    push_str("AxC");
    push_str("ayzc");
    push_str("ab");
    push_byte("a", 1'b0);  // name left open, the next write restarts it
    wait_idle();

    // zero byte as a literal, high byte unchanged, upper case text
    new_pat = '{default: 8'h00};
    new_pat[1] = 8'h80;
    new_pat[2] = "z";
    set_pattern(6'd3, '0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte("Z", 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte("z", 1'b1);
    wait_idle();

    // oversized length clamps to the full pattern
    new_pat = '{default: STAR_CHAR};
    set_pattern(6'd63, '0);
    push_byte(8'h7F, 1'b1);
    wait_idle();

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      random_pattern(len);
      set_pattern(len, 58'({$urandom, $urandom}));
      burst_in = ($urandom_range(0, 3) == 0);
      burst_out = ($urandom_range(0, 3) == 0);
      added = 0;
      while (added < PHASE_BYTES) begin
        start_sz = pending.size();
        push_name();
        added += pending.size() - start_sz;
      end
      if (ph % 5 == 4) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      wait_idle();
    end

    $display("Streamed %0d names (%0d matching) over %0d pattern settings,",
             names_done, names_hit, settings);
    $display("including empty, clamped and full-length patterns and mid-name rewrites.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
sv/gwm_pkg.sv
sv/gwm_closure.sv
sv/gwm_step.sv
sv/glob_wildcard_matcher_top.sv
tb/tb.sv
